>>> design/lpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants for the linear probe hash table
// Slot word layout, request and response codes, and the per-probe decision
// that passes from the probe unit to the sequencer.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int KEY_WIDTH            = 32;
	localparam int VALUE_WIDTH          = 32;
	localparam int TABLE_SIZE_DEF       = 1024;
	localparam int MAX_EXTRA_PROBES_DEF = 20;

	// stream word widths, padded to whole bytes
	localparam int S_TDATA_W = ((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8;
	localparam int M_TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;
	localparam int S_TUSER_W = 2;
	localparam int M_TUSER_W = 3;

	typedef enum logic [1:0] {
		SLOT_EMPTY   = 2'd0,
		SLOT_LIVE    = 2'd1,
		SLOT_DELETED = 2'd2
	} slot_state_e;

	typedef enum logic [1:0] {
		REQ_SEARCH    = 2'd0,
		REQ_INSERT    = 2'd1,
		REQ_INSERT_EX = 2'd2,
		REQ_DELETE    = 2'd3
	} req_e;

	typedef enum logic [1:0] {
		RSP_DONE      = 2'd0,
		RSP_NOT_FOUND = 2'd1,
		RSP_FULL      = 2'd2
	} rsp_status_e;

	typedef struct packed {
		slot_state_e              state;
		logic [KEY_WIDTH-1:0]     key;
		logic [VALUE_WIDTH-1:0]   value;
	} slot_t;

	typedef struct packed {
		logic                     finish;
		logic                     wr_en;
		slot_t                    wr_slot;
		rsp_status_e              status;
		logic                     existed;
		logic [VALUE_WIDTH-1:0]   value_out;
		logic                     live_inc;
		logic                     live_dec;
	} probe_dec_t;

endpackage

>>> design/lpht_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_slot_ram: slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpht_slot_ram #(
	parameter int DEPTH = lpht_pkg::TABLE_SIZE_DEF,
	parameter int WIDTH = $bits(lpht_pkg::slot_t)
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> design/lpht_probe_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_probe_unit: per-slot key compare and decision
// Looks at one slot word and decides whether the request ends there, what
// is written back and what is answered.
// ----------------------------------------------------------------------------
module lpht_probe_unit (
	input  lpht_pkg::slot_t                       slot,
	input  lpht_pkg::req_e                        req,
	input  logic [lpht_pkg::KEY_WIDTH-1:0]        key,
	input  logic [lpht_pkg::VALUE_WIDTH-1:0]      value,
	input  logic                                  over_limit,
	input  logic                                  last_probe,
	output lpht_pkg::probe_dec_t                  dec
);

	logic key_match;
	logic is_insert;

	assign key_match = (slot.key == key);
	assign is_insert = (req == lpht_pkg::REQ_INSERT) || (req == lpht_pkg::REQ_INSERT_EX);

	always_comb begin
		dec               = '0;
		dec.status        = lpht_pkg::RSP_NOT_FOUND;
		dec.wr_slot.state = lpht_pkg::SLOT_LIVE;
		dec.wr_slot.key   = key;
		dec.wr_slot.value = value;
		if (is_insert) begin
			if (over_limit) begin
				dec.finish = 1'b1;
				dec.status = lpht_pkg::RSP_FULL;
			end else if (slot.state != lpht_pkg::SLOT_LIVE) begin
				// claim an empty or deleted slot
				dec.finish    = 1'b1;
				dec.wr_en     = 1'b1;
				dec.status    = lpht_pkg::RSP_DONE;
				dec.value_out = value;
				dec.live_inc  = 1'b1;
			end else if (key_match) begin
				dec.finish    = 1'b1;
				dec.wr_en     = 1'b1;
				dec.status    = lpht_pkg::RSP_DONE;
				dec.value_out = value;
				dec.existed   = (req == lpht_pkg::REQ_INSERT_EX);
			end else if (last_probe) begin
				dec.finish = 1'b1;
				dec.status = lpht_pkg::RSP_FULL;
			end
		end else begin
			if (slot.state == lpht_pkg::SLOT_EMPTY) begin
				dec.finish = 1'b1;
			end else if (slot.state == lpht_pkg::SLOT_LIVE && key_match) begin
				dec.finish = 1'b1;
				dec.status = lpht_pkg::RSP_DONE;
				if (req == lpht_pkg::REQ_SEARCH) begin
					dec.value_out = slot.value;
				end else begin
					// delete leaves a tombstone, key and value kept
					dec.wr_en         = 1'b1;
					dec.wr_slot.state = lpht_pkg::SLOT_DELETED;
					dec.wr_slot.key   = slot.key;
					dec.wr_slot.value = slot.value;
					dec.live_dec      = 1'b1;
				end
			end else if (last_probe) begin
				dec.finish = 1'b1;
			end
		end
	end

endmodule

>>> design/linear_probe_hash_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit: open-addressed key/value table, linear probing
// Search, insert, insert-with-existence-flag and delete on a slot memory
// of TABLE_SIZE entries, one probe per clock through a shared compare unit.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot memory to mark every slot empty, with
// s_axis_tready low. Then each request word is accepted, its home slot
// ((key >> 2) mod TABLE_SIZE) is formed by reciprocal multiply in ST_HASH
// and ST_ADDR, and up to MAX_EXTRA_PROBES + 1 slots are probed, one slot read
// per cycle from the single read port of the slot memory. One request is in
// flight at a time; the answer sits in an output register, so the next
// request can be taken while it waits on m_axis_tready.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit #(
	parameter int TABLE_SIZE       = lpht_pkg::TABLE_SIZE_DEF,
	parameter int MAX_EXTRA_PROBES = lpht_pkg::MAX_EXTRA_PROBES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [31:0] key, [63:32] value
	input  logic [lpht_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// [1:0] req_type
	input  logic [lpht_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [31:0] value_out
	output logic [lpht_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// [1:0] status, [2] existed
	output logic [lpht_pkg::M_TUSER_W-1:0] m_axis_tuser
);

	localparam int KW     = lpht_pkg::KEY_WIDTH;
	localparam int VW     = lpht_pkg::VALUE_WIDTH;
	localparam int IDX_W  = $clog2(TABLE_SIZE);
	localparam int CNT_W  = $clog2(MAX_EXTRA_PROBES + 1);
	localparam int LIVE_W = $clog2(TABLE_SIZE + 1);
	// home slot hashing: x = key >> 2, r = x mod TABLE_SIZE
	localparam int XW     = KW - 2;
	localparam int SHIFT  = XW + IDX_W;
	localparam int PROD_W = 2 * XW + 1;
	localparam int Q_W    = PROD_W - SHIFT;
	localparam logic [63:0] RECIP64 =
		((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
	localparam logic [XW:0] RECIP = RECIP64[XW:0];
	localparam logic [LIVE_W-1:0] LOAD_LIMIT = LIVE_W'(TABLE_SIZE * 8 / 10);
	localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(TABLE_SIZE - 1);
	localparam logic [CNT_W-1:0]  LAST_CNT   = CNT_W'(MAX_EXTRA_PROBES);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_HASH  = 5'b00100,
		ST_ADDR  = 5'b01000,
		ST_PROBE = 5'b10000
	} state_t;

	state_t                 state_q;
	lpht_pkg::req_e         req_q;
	logic [KW-1:0]          key_q;
	logic [VW-1:0]          value_q;
	logic [PROD_W-1:0]      prod_q;
	logic [IDX_W-1:0]       idx_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [LIVE_W-1:0]      live_q;

	logic                   m_valid_q;
	lpht_pkg::rsp_status_e  status_q;
	logic                   existed_q;
	logic [VW-1:0]          value_out_q;

	logic [IDX_W-1:0]       idx_next;
	logic [XW-1:0]          hash_x;
	logic [Q_W-1:0]         quot;
	logic [XW-1:0]          quot_n;
	logic [XW-1:0]          rem_full;
	logic [IDX_W-1:0]       home_idx;

	logic                   out_free;
	logic                   ram_wr_en;
	logic [IDX_W-1:0]       ram_wr_addr;
	lpht_pkg::slot_t        ram_wr_slot;
	logic                   ram_rd_en;
	logic [IDX_W-1:0]       ram_rd_addr;
	logic [$bits(lpht_pkg::slot_t)-1:0] ram_rd_data;
	lpht_pkg::slot_t        rd_slot;
	lpht_pkg::probe_dec_t   dec;
	logic                   probe_end;

	// wrap to slot 0 after the last slot
	assign idx_next = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

	// floor(x / N) = (x * ceil(2^SHIFT / N)) >> SHIFT, exact for x < 2^XW
	assign hash_x   = key_q[KW-1:2];
	assign quot     = prod_q[SHIFT +: Q_W];
	assign quot_n   = XW'(quot) * XW'(TABLE_SIZE);
	assign rem_full = hash_x - quot_n;
	assign home_idx = rem_full[IDX_W-1:0];

	assign out_free  = !m_valid_q || m_axis_tready;
	assign probe_end = (state_q == ST_PROBE) && dec.finish && out_free;

	assign s_axis_tready = (state_q == ST_IDLE);

	// slot memory ports: the sweep and the final probe write, probes read
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = idx_q;
		ram_wr_slot = dec.wr_slot;
		ram_rd_en   = 1'b0;
		ram_rd_addr = idx_next;
		if (state_q == ST_CLEAR) begin
			ram_wr_en   = 1'b1;
			ram_wr_slot = '0;
		end else if (probe_end) begin
			ram_wr_en = dec.wr_en;
		end
		if (state_q == ST_ADDR) begin
			ram_rd_en   = 1'b1;
			ram_rd_addr = home_idx;
		end else if (state_q == ST_PROBE && !dec.finish) begin
			// read the next slot while this one is checked
			ram_rd_en = 1'b1;
		end
	end

	lpht_slot_ram #(
		.DEPTH (TABLE_SIZE),
		.WIDTH ($bits(lpht_pkg::slot_t))
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_slot),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign rd_slot = lpht_pkg::slot_t'(ram_rd_data);

	lpht_probe_unit u_probe (
		.slot       (rd_slot),
		.req        (req_q),
		.key        (key_q),
		.value      (value_q),
		.over_limit (live_q > LOAD_LIMIT),
		.last_probe (cnt_q == LAST_CNT),
		.dec        (dec)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q   <= '0;
			cnt_q   <= '0;
			live_q  <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_next;
					if (idx_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					state_q <= ST_ADDR;
				end
				ST_ADDR: begin
					idx_q   <= home_idx;
					cnt_q   <= '0;
					state_q <= ST_PROBE;
				end
				ST_PROBE: begin
					if (!dec.finish) begin
						idx_q <= idx_next;
						cnt_q <= cnt_q + 1'b1;
					end else if (out_free) begin
						if (dec.live_inc) begin
							live_q <= live_q + 1'b1;
						end else if (dec.live_dec && live_q != '0) begin
							live_q <= live_q - 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// request word and hash product
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_q   <= lpht_pkg::req_e'(s_axis_tuser[1:0]);
			key_q   <= s_axis_tdata[KW-1:0];
			value_q <= s_axis_tdata[KW +: VW];
		end
		if (state_q == ST_HASH) begin
			prod_q <= PROD_W'(hash_x) * PROD_W'(RECIP);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (probe_end) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (probe_end) begin
			status_q    <= dec.status;
			existed_q   <= dec.existed;
			value_out_q <= dec.value_out;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = lpht_pkg::M_TDATA_W'(value_out_q);
	assign m_axis_tuser  = {existed_q, status_q};

endmodule

>>> design/lpht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_checker: port-level checks for the hash table unit
// Watches the stream ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module lpht_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [lpht_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic [lpht_pkg::M_TUSER_W-1:0] m_axis_tuser
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// one request at a time: no accept right after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request taken while one is in flight");

	// existed only with a done status
	a_existed_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == lpht_pkg::RSP_DONE)
		else $error("existed set on a failed request");

	// not found and full carry a zero value
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] != lpht_pkg::RSP_DONE |-> m_axis_tdata == '0)
		else $error("nonzero value on a failed request");

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
